// ----- rtl/core/dht_pkg.sv -----
// ----------------------------------------------------------------------------
// dht_pkg: shared types, constants and microcode for the double hash table
// Payload structs, slot and status codes, and the read-only control program
// that sequences the table engine datapath.
// ----------------------------------------------------------------------------
package dht_pkg;

   // table geometry
   localparam int NUM_SLOTS  = 1021;
   localparam int SLOT_W     = $clog2(NUM_SLOTS);
   localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
   localparam int PRB_W      = $clog2(NUM_SLOTS + 1);
   localparam int LOAD_LIMIT = (NUM_SLOTS / 4) * 3;

   // hash reduction: one hex digit per step
   localparam int HASH_W    = 32;
   localparam int DIGIT_W   = 4;
   localparam int N_DIGITS  = HASH_W / DIGIT_W;
   localparam int DIG_CNT_W = $clog2(N_DIGITS);
   localparam int EXT_W     = SLOT_W + DIGIT_W;

   // field widths
   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int VAL_W    = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 10;
   localparam int SLOT_ST_W = 2;

   // opcodes
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_SET    = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd5;

   // slot states
   localparam logic [SLOT_ST_W-1:0] SLOT_FREE    = 2'd0;
   localparam logic [SLOT_ST_W-1:0] SLOT_LIVE    = 2'd1;
   localparam logic [SLOT_ST_W-1:0] SLOT_DELETED = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] key_hash;
      logic [VAL_W-1:0]  value;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    found_value;
      logic [COUNT_W-1:0]  entry_count;
      logic                load_high;
   } rsp_payload_type;

   typedef struct packed {
      logic [SLOT_ST_W-1:0] status;
      logic [KEY_W-1:0]     key;
      logic [VAL_W-1:0]     value;
   } slot_type;

   localparam int SLOT_BITS = $bits(slot_type);

   // microcode
   typedef enum logic [2:0] {
      UOP_NOP,
      UOP_CLEAR,
      UOP_ACCEPT,
      UOP_MOD,
      UOP_READ,
      UOP_CHECK,
      UOP_COMMIT,
      UOP_EMIT
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_CLR_MORE,
      COND_NO_REQ,
      COND_DIGITS_LEFT,
      COND_PROBE_ON,
      COND_RSP_FREE
   } cond_type;

   localparam int STEP_W = 3;

   localparam logic [STEP_W-1:0] STEP_CLEAR  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MOD    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_READ   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_CHECK  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_COMMIT = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;
   localparam logic [STEP_W-1:0] STEP_RETRY  = 3'd7;

   typedef struct packed {
      uop_type           uop;
      cond_type          cond;
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   // jump to target when cond holds, else fall through to the next step
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type w;
      case (step)
         STEP_CLEAR:  w = '{UOP_CLEAR,  COND_CLR_MORE,    STEP_CLEAR};
         STEP_IDLE:   w = '{UOP_ACCEPT, COND_NO_REQ,      STEP_IDLE};
         STEP_MOD:    w = '{UOP_MOD,    COND_DIGITS_LEFT, STEP_MOD};
         STEP_READ:   w = '{UOP_READ,   COND_NEVER,       STEP_READ};
         STEP_CHECK:  w = '{UOP_CHECK,  COND_PROBE_ON,    STEP_READ};
         STEP_COMMIT: w = '{UOP_COMMIT, COND_NEVER,       STEP_COMMIT};
         STEP_EMIT:   w = '{UOP_EMIT,   COND_RSP_FREE,    STEP_IDLE};
         STEP_RETRY:  w = '{UOP_NOP,    COND_ALWAYS,      STEP_EMIT};
         default:     w = '{UOP_NOP,    COND_ALWAYS,      STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/dht_ram.sv -----
// ----------------------------------------------------------------------------
// dht_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; the read
// register holds its value while rd_en is low.
// ----------------------------------------------------------------------------
module dht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/double_hash_table_engine_core.sv -----
// ----------------------------------------------------------------------------
// double_hash_table_engine_core: open-addressing key/value table engine
// Lookup, set and remove on a fixed table using double hashing, run by a
// small microcoded sequencer over one slot RAM.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | direction | moves
//  ---------+--------------------------------+-----------+-------------------
//  request  | req_valid req_ready req_payload| in        | one operation
//  response | rsp_valid rsp_ready rsp_payload| out       | one result per op
//
// Probing: P = 1..NUM_SLOTS probes per operation. The probe loop is one RAM
//   read and one check per slot; the hash is reduced mod size and mod size-1
//   one hex digit per cycle, over all 8 digits.
// Reset: synchronous; then a clearing pass writes every slot free while
//   req_ready stays low.
// Stalls: a finished result sits in the output register; the next request is
//   taken meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module double_hash_table_engine_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dht_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dht_pkg::rsp_payload_type rsp_payload
);

   localparam int SLOT_W = dht_pkg::SLOT_W;
   localparam int EXT_W  = dht_pkg::EXT_W;
   localparam int CNT_W  = dht_pkg::CNT_W;
   localparam int PRB_W  = dht_pkg::PRB_W;

   localparam logic [EXT_W-1:0]  MOD_A      = EXT_W'(dht_pkg::NUM_SLOTS);
   localparam logic [EXT_W-1:0]  MOD_B      = EXT_W'(dht_pkg::NUM_SLOTS - 1);
   localparam logic [SLOT_W:0]   SIZE_SUM   = (SLOT_W + 1)'(dht_pkg::NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(dht_pkg::NUM_SLOTS - 1);
   localparam logic [PRB_W-1:0]  PROBE_MAX  = PRB_W'(dht_pkg::NUM_SLOTS);
   localparam logic [CNT_W-1:0]  LOAD_LIM   = CNT_W'(dht_pkg::LOAD_LIMIT);
   localparam logic [dht_pkg::DIG_CNT_W-1:0] LAST_DIGIT =
      dht_pkg::DIG_CNT_W'(dht_pkg::N_DIGITS - 1);

   // (rem * 16 + digit) mod m, with rem < m: four compare-subtract steps
   function automatic logic [EXT_W-1:0] mod_digit(input logic [EXT_W-1:0] v,
                                                  input logic [EXT_W-1:0] m);
      logic [EXT_W-1:0] r;
      r = v;
      for (int k = dht_pkg::DIGIT_W - 1; k >= 0; k--) begin
         if (r >= (m << k)) begin
            r = r - (m << k);
         end
      end
      return r;
   endfunction

   // sequencer
   dht_pkg::ctrl_word_type     ctrl;
   logic [dht_pkg::STEP_W-1:0] pc_ff, pc_in;
   logic                       jump;

   // datapath registers
   dht_pkg::req_payload_type        req_ff, req_in;
   logic [dht_pkg::HASH_W-1:0]      hash_sh_ff, hash_sh_in;
   logic [dht_pkg::DIG_CNT_W-1:0]   digit_ff, digit_in;
   logic [SLOT_W-1:0]               pos_ff, pos_in;      // hash mod size, then probe slot
   logic [SLOT_W-1:0]               step_ff, step_in;    // hash mod (size-1) = stride-1
   logic [PRB_W-1:0]                probe_ff, probe_in;
   logic [SLOT_W-1:0]               clr_ff, clr_in;
   logic [CNT_W-1:0]                live_ff, live_in;
   logic [dht_pkg::STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [dht_pkg::VAL_W-1:0]       res_found_ff, res_found_in;
   dht_pkg::rsp_payload_type        rsp_ff, rsp_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // slot RAM port
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   dht_pkg::slot_type ram_wdata;
   logic              ram_re;
   dht_pkg::slot_type ram_rdata;
   logic [dht_pkg::SLOT_BITS-1:0] ram_rd_bits;

   // combinational helpers
   logic [EXT_W-1:0]   mod_a_ext, mod_b_ext;
   logic [SLOT_W:0]    pos_sum;
   logic [SLOT_W-1:0]  pos_next;
   logic               slot_free, slot_match, probe_on, rsp_free;
   logic [CNT_W+9:0]   count_ext;

   dht_ram #(
      .WIDTH (dht_pkg::SLOT_BITS),
      .DEPTH (dht_pkg::NUM_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_bits)
   );

   assign ram_rdata = dht_pkg::slot_type'(ram_rd_bits);
   assign ctrl      = dht_pkg::ucode_rom(pc_ff);

   // probe evaluation on the registered read data
   assign slot_free  = (ram_rdata.status == dht_pkg::SLOT_FREE);
   assign slot_match = (ram_rdata.status == dht_pkg::SLOT_LIVE) &&
                       (ram_rdata.key == req_ff.key);
   assign probe_on   = !slot_free && !slot_match && (probe_ff != PROBE_MAX);

   // next slot: pos + stride, both below size, so one subtract wraps it
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, step_ff} + (SLOT_W + 1)'(1);
   assign pos_next = (pos_sum >= SIZE_SUM) ? SLOT_W'(pos_sum - SIZE_SUM)
                                           : pos_sum[SLOT_W-1:0];

   assign mod_a_ext = mod_digit({pos_ff,
                                 hash_sh_ff[dht_pkg::HASH_W-1 -: dht_pkg::DIGIT_W]}, MOD_A);
   assign mod_b_ext = mod_digit({step_ff,
                                 hash_sh_ff[dht_pkg::HASH_W-1 -: dht_pkg::DIGIT_W]}, MOD_B);

   // output register frees when empty or being taken this cycle
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign count_ext = (CNT_W + 10)'(live_ff);

   // jump condition
   always_comb begin
      case (ctrl.cond)
         dht_pkg::COND_NEVER:       jump = 1'b0;
         dht_pkg::COND_ALWAYS:      jump = 1'b1;
         dht_pkg::COND_CLR_MORE:    jump = (clr_ff != LAST_SLOT);
         dht_pkg::COND_NO_REQ:      jump = !req_valid;
         dht_pkg::COND_DIGITS_LEFT: jump = (digit_ff != LAST_DIGIT);
         dht_pkg::COND_PROBE_ON:    jump = probe_on;
         dht_pkg::COND_RSP_FREE:    jump = rsp_free;
         default:                   jump = 1'b0;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + dht_pkg::STEP_W'(1);
   end

   // datapath driven by the control word
   always_comb begin
      req_in        = req_ff;
      hash_sh_in    = hash_sh_ff;
      digit_in      = digit_ff;
      pos_in        = pos_ff;
      step_in       = step_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      live_in       = live_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = ram_rdata;
      ram_re        = 1'b0;

      case (ctrl.uop)
         dht_pkg::UOP_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '{dht_pkg::SLOT_FREE, '0, '0};
            clr_in    = clr_ff + SLOT_W'(1);
         end
         dht_pkg::UOP_ACCEPT: begin
            if (req_valid) begin
               req_in     = req_payload;
               hash_sh_in = req_payload.key_hash;
               digit_in   = '0;
               pos_in     = '0;
               step_in    = '0;
               probe_in   = '0;
            end
         end
         dht_pkg::UOP_MOD: begin
            pos_in     = mod_a_ext[SLOT_W-1:0];
            step_in    = mod_b_ext[SLOT_W-1:0];
            hash_sh_in = hash_sh_ff << dht_pkg::DIGIT_W;
            digit_in   = digit_ff + dht_pkg::DIG_CNT_W'(1);
         end
         dht_pkg::UOP_READ: begin
            ram_re   = 1'b1;
            probe_in = probe_ff + PRB_W'(1);
         end
         dht_pkg::UOP_CHECK: begin
            // hold the slot on a stop so commit writes it
            if (probe_on) begin
               pos_in = pos_next;
            end
         end
         dht_pkg::UOP_COMMIT: begin
            res_status_in = dht_pkg::ST_MISS;
            res_found_in  = '0;
            if (req_ff.opcode != dht_pkg::OP_LOOKUP &&
                req_ff.opcode != dht_pkg::OP_SET &&
                req_ff.opcode != dht_pkg::OP_REMOVE) begin
               res_status_in = dht_pkg::ST_MISS;
            end else if (!slot_free && !slot_match) begin
               res_status_in = dht_pkg::ST_FULL;
            end else if (req_ff.opcode == dht_pkg::OP_LOOKUP) begin
               if (slot_match) begin
                  res_status_in = dht_pkg::ST_HIT;
                  res_found_in  = ram_rdata.value;
               end
            end else if (req_ff.opcode == dht_pkg::OP_SET) begin
               ram_we    = 1'b1;
               ram_wdata = '{dht_pkg::SLOT_LIVE, req_ff.key, req_ff.value};
               if (slot_match) begin
                  res_status_in = dht_pkg::ST_UPDATED;
               end else begin
                  res_status_in = dht_pkg::ST_INSERTED;
                  live_in       = live_ff + CNT_W'(1);
               end
            end else begin
               if (slot_match) begin
                  ram_we        = 1'b1;
                  ram_wdata     = '{dht_pkg::SLOT_DELETED, ram_rdata.key,
                                    ram_rdata.value};
                  res_status_in = dht_pkg::ST_REMOVED;
                  if (live_ff != '0) begin
                     live_in = live_ff - CNT_W'(1);
                  end
               end
            end
         end
         dht_pkg::UOP_EMIT: begin
            if (rsp_free) begin
               rsp_in.status      = res_status_ff;
               rsp_in.found_value = res_found_ff;
               rsp_in.entry_count = count_ext[9:0];
               rsp_in.load_high   = (live_ff > LOAD_LIM);
               rsp_valid_in       = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= dht_pkg::STEP_CLEAR;
         clr_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         clr_ff       <= clr_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff        <= req_in;
      hash_sh_ff    <= hash_sh_in;
      digit_ff      <= digit_in;
      pos_ff        <= pos_in;
      step_ff       <= step_in;
      probe_ff      <= probe_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_ff        <= rsp_in;
   end

   assign req_ready   = (ctrl.uop == dht_pkg::UOP_ACCEPT);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
